@@ src/cdgv_pkg.sv @@
package cdgv_pkg;

  localparam int MAX_X = 128;
  localparam int MAX_Y = 128;
  localparam int MAX_Z = 128;

  localparam int CW     = 7;   // coordinate width
  localparam int SW     = 8;   // size register width
  localparam int DW     = 16;  // sample width
  localparam int GW     = 17;  // gradient / magnitude width
  localparam int AW     = 15;  // store address: plane parity, y, x
  localparam int SUMW   = 34;  // sum of three squares
  localparam int ODW    = 112; // packed result width

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic [DW-1:0] sample;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] p;
    logic          interior;
    logic          last;
  } cdgv_item_t;

endpackage

@@ src/cdgv_front.sv @@
module cdgv_front import cdgv_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [SW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] in_sample_i,
  output logic          push_o,
  output cdgv_item_t    item_o,
  input  logic          full_i
);

  logic [SW-1:0] size_x_q, size_y_q, size_z_q;
  logic [CW-1:0] x_q, y_q, p_q, x_d, y_d, p_d;
  logic [SW-1:0] clamped, lim, x1, y1, p1;
  logic          end_x, end_y, end_z, accept;

  always_comb begin
    case (cfg_idx_i)
      REG_SIZE_Y: lim = SW'(MAX_Y);
      REG_SIZE_Z: lim = SW'(MAX_Z);
      default:    lim = SW'(MAX_X);
    endcase
    if (cfg_data_i == '0) clamped = SW'(1);
    else if (cfg_data_i > lim) clamped = lim;
    else clamped = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SW'(MAX_X);
      size_y_q <= SW'(MAX_Y);
      size_z_q <= SW'(MAX_Z);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= clamped;
        REG_SIZE_Y: size_y_q <= clamped;
        REG_SIZE_Z: size_z_q <= clamped;
        default: ;
      endcase
    end
  end

  assign x1 = {1'b0, x_q} + SW'(1);
  assign y1 = {1'b0, y_q} + SW'(1);
  assign p1 = {1'b0, p_q} + SW'(1);
  assign end_x = x1 >= size_x_q;
  assign end_y = y1 >= size_y_q;
  assign end_z = p1 >= size_z_q;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    item_o.sample   = in_sample_i;
    item_o.x        = x_q;
    item_o.y        = y_q;
    item_o.p        = p_q;
    item_o.interior = (p_q >= CW'(2)) && (x_q != '0) && !end_x && (y_q != '0) && !end_y
                      && ({1'b0, p_q} < size_z_q);
    item_o.last     = end_x && end_y && end_z;
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    p_d = p_q;
    if (item_o.last) begin
      x_d = '0; y_d = '0; p_d = '0;
    end else if (end_x) begin
      x_d = '0;
      if (end_y) begin
        y_d = '0;
        p_d = end_z ? '0 : p1[CW-1:0];
      end else begin
        y_d = y1[CW-1:0];
      end
    end else begin
      x_d = x1[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; p_q <= '0;
    end else if (accept) begin
      x_q <= x_d; y_q <= y_d; p_q <= p_d;
    end
  end

endmodule

@@ src/cdgv_fifo.sv @@
module cdgv_fifo import cdgv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cdgv_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output cdgv_item_t item_o
);

  cdgv_item_t mem_q [4];
  logic [2:0] wp_q, rp_q;

  assign full_o  = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
  assign empty_o = wp_q == rp_q;
  assign item_o  = mem_q[rp_q[1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q[1:0]] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 3'd1;
      if (pop_i)  rp_q <= rp_q + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && empty_o) |=> !empty_o) else $error("lost item");
`endif

endmodule

@@ src/cdgv_back.sv @@
module cdgv_back import cdgv_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  cdgv_item_t     item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [ODW-1:0] out_data_o,
  output logic           out_last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [DW-1:0]    store [1 << AW];
  logic [DW-1:0]    rdata_q;
  logic [AW-1:0]    raddr, waddr;
  logic [DW-1:0]    wdata;
  logic             we;
  cdgv_item_t       cur_q;
  logic [DW-1:0]    v_q [5];
  logic [2:0]       cnt_q;
  logic [4:0]       it_q;
  logic signed [GW-1:0] gx_q, gy_q, gz_q, gsel;
  logic [DW-1:0]    gabs;
  logic [2*DW-1:0]  sq_q;
  logic             sq_v_q;
  logic [SUMW-1:0]  sum_q, n_q;
  logic [19:0]      rem_q, r2, tr;
  logic [GW-1:0]    root_q, peak_q, peak_new;
  logic             summ_q, out_v_q, out_l_q, load;
  logic [ODW-1:0]   out_q;
  logic [CW-1:0]    pz, xa;
  logic [CW-1:0]    ya;
  logic             pa;

  // read address per step: x+1, x-1, y+1, y-1 in plane z-1, then plane z-2
  always_comb begin
    xa = cur_q.x; ya = cur_q.y; pa = ~cur_q.p[0];
    case (cnt_q)
      3'd0: xa = cur_q.x + CW'(1);
      3'd1: xa = cur_q.x - CW'(1);
      3'd2: ya = cur_q.y + CW'(1);
      3'd3: ya = cur_q.y - CW'(1);
      default: pa = cur_q.p[0];
    endcase
    raddr = {pa, ya, xa};
  end

  always_comb begin
    we = 1'b0; waddr = {item_i.p[0], item_i.y, item_i.x}; wdata = item_i.sample;
    if (state_q == S_IDLE && !empty_i && !item_i.interior) we = 1'b1;
    if (state_q == S_WR) begin
      we = 1'b1; waddr = {cur_q.p[0], cur_q.y, cur_q.x}; wdata = cur_q.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) store[waddr] <= wdata;
    rdata_q <= store[raddr];
  end

  assign pop_o = state_q == S_IDLE && !empty_i;
  assign load  = state_q == S_OUT && (!out_v_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!empty_i) begin
        if (item_i.interior) state_d = S_RD;
        else if (item_i.last) state_d = S_OUT;
      end
      S_RD:   if (cnt_q == 3'd5) state_d = S_WR;
      S_WR:   state_d = S_SQ;
      S_SQ:   if (cnt_q == 3'd3) state_d = S_SQRT;
      S_SQRT: if (it_q == 5'd16) state_d = S_OUT;
      S_OUT:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (cnt_q)
      3'd0: gsel = gx_q;
      3'd1: gsel = gy_q;
      default: gsel = gz_q;
    endcase
    gabs = gsel[GW-1] ? DW'(-gsel) : gsel[DW-1:0];
  end

  assign r2 = {rem_q[17:0], n_q[SUMW-1 -: 2]};
  assign tr = {1'b0, root_q, 2'b01};
  assign peak_new = (root_q > peak_q) ? root_q : peak_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cur_q  <= item_i;
        summ_q <= !item_i.interior;
      end
      S_RD: if (cnt_q != 3'd0) v_q[cnt_q - 3'd1] <= rdata_q;
      S_WR: begin
        gx_q <= GW'(v_q[0]) - GW'(v_q[1]);
        gy_q <= GW'(v_q[2]) - GW'(v_q[3]);
        gz_q <= GW'(cur_q.sample) - GW'(v_q[4]);
        sum_q <= '0;
      end
      S_SQ: begin
        sq_q <= gabs * gabs;
        if (sq_v_q) sum_q <= sum_q + SUMW'(sq_q);
        rem_q <= '0; root_q <= '0;
      end
      S_SQRT: begin
        if (it_q == 5'd0) begin
          n_q <= sum_q << 2;
          rem_q <= {18'd0, sum_q[SUMW-1 -: 2]} >= 20'd1
                   ? {18'd0, sum_q[SUMW-1 -: 2]} - 20'd1 : {18'd0, sum_q[SUMW-1 -: 2]};
          root_q <= GW'(sum_q[SUMW-1 -: 2] != 2'd0);
        end else begin
          n_q <= n_q << 2;
          if (r2 >= tr) begin
            rem_q <= r2 - tr; root_q <= {root_q[GW-2:0], 1'b1};
          end else begin
            rem_q <= r2; root_q <= {root_q[GW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
    if (load) begin
      if (summ_q) out_q <= {6'd0, peak_q, 89'd0};
      else out_q <= {6'd0, peak_new, root_q, gz_q, gy_q, gx_q, pz, cur_q.y, cur_q.x};
    end
  end

  assign pz = cur_q.p - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; it_q <= '0; sq_v_q <= 1'b0;
      peak_q <= '0; out_v_q <= 1'b0; out_l_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else if (state_q == S_RD || state_q == S_SQ) cnt_q <= cnt_q + 3'd1;
      sq_v_q <= state_q == S_SQ;
      if (state_q == S_SQRT) it_q <= it_q + 5'd1;
      else it_q <= '0;
      if (load) begin
        out_v_q <= 1'b1;
        out_l_q <= summ_q;
        peak_q  <= summ_q ? '0 : peak_new;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign out_last_o  = out_l_q;

`ifndef SYNTHESIS
  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_l_q) |-> (out_q[88:0] == '0)) else $error("summary not cleared");
  a_peak_ge_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_l_q) |-> (out_q[105:89] >= out_q[88:72])) else $error("peak below mag");
  a_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !pop_o || $past(!item_i.interior)) else $error("pop while busy");
`endif

endmodule

@@ src/central_difference_gradient_volume.sv @@
// channel  dir  handshake                 payload
// s_axis   in   tvalid/tready             tdata: sample
// m_axis   out  tvalid/tready             tdata: pos_x..peak_magnitude, tlast: is_summary
// cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i (size_x/y/z)
// Front takes one sample a cycle into a 4-deep queue while it has room. Back pops and
// stores a boundary sample, also loads the output for the summary, and takes an interior
// one via pop, 5 registered store reads, write, 3 shared squarings, 17 root steps, output load.
// The output register parts back from m_axis stalls; a full queue drops s_axis_tready_o.
// Reset clears counters and control; the plane store needs no clearing pass.
module central_difference_gradient_volume import cdgv_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [SW-1:0]  cfg_data_i,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [DW-1:0]  s_axis_tdata_i,  // sample
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // pos_x, pos_y, pos_z, grad_x, grad_y, grad_z, magnitude, peak_magnitude, pad
  output logic [ODW-1:0] m_axis_tdata_o,
  output logic           m_axis_tlast_o   // is_summary
);

  cdgv_item_t push_item, pop_item;
  logic       push, pop, full, empty;

  cdgv_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_sample_i(s_axis_tdata_i), .push_o(push), .item_o(push_item), .full_i(full)
  );

  cdgv_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(pop_item)
  );

  cdgv_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(pop_item), .pop_o(pop),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_data_o(m_axis_tdata_o), .out_last_o(m_axis_tlast_o)
  );

endmodule
